### src/vrq_pkg.sv
// Shared types and constants for the variable record ring queue.
// No dependencies; used by vrq_front, vrq_back and the top level.
package vrq_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int LEN_W        = 13;
    localparam int TOTAL_W      = 14;

    typedef enum logic [1:0] {
        ACT_START_WRITE = 2'd0,
        ACT_WRITE_BYTE  = 2'd1,
        ACT_START_READ  = 2'd2,
        ACT_READ_BYTE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OK_EMPTY  = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_OVER_LIM  = 3'd4,
        ST_OUT_OF_SEQ = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WR_HDR,
        BK_RD_HDR,
        BK_RD_BYTE
    } back_state_t;

    typedef struct packed {
        action_t            action;
        logic [LEN_W-1:0]   write_length;
        logic [31:0]        flow_tag;
        logic [7:0]         data_in;
        logic [LEN_W-1:0]   read_limit;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   read_length;
        logic [31:0]        read_flow;
        logic [7:0]         data_out;
        logic               last_byte;
        logic [31:0]        enqueued_total;
        logic [31:0]        dequeued_total;
    } result_t;

endpackage

### src/vrq_front.sv
// Front end: accepts input beats into a two-entry queue ahead of the back end.
// Depends on vrq_pkg.
module vrq_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  vrq_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_pop,
    output vrq_pkg::item_t out_item
);

    vrq_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### src/vrq_back.sv
// Back end: ring byte store, pointers, header sequencer and result register.
// Depends on vrq_pkg.
module vrq_back #(
    parameter int RING_BYTES = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  vrq_pkg::item_t   in_item,
    output logic             in_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output vrq_pkg::result_t out_res
);

    localparam int AW = $clog2(RING_BYTES);
    localparam int FW = AW + 1;
    localparam int CW = (FW > vrq_pkg::TOTAL_W) ? FW : vrq_pkg::TOTAL_W;
    localparam int LW = vrq_pkg::LEN_W;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == AW'(RING_BYTES - 1)) ? '0 : p + AW'(1);
    endfunction

    logic [7:0] ring_mem [RING_BYTES];
    logic [7:0] ring_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] store_addr;
    logic [7:0]    mem_wdata;

    vrq_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0] wcur_reg, wcur_next, rcur_reg, rcur_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [LW-1:0] wleft_reg, wleft_next, rleft_reg, rleft_next;
    logic [31:0]   enq_reg, enq_next, deq_reg, deq_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [63:0]   hdr_reg, hdr_next;
    vrq_pkg::item_t   item_reg, item_next;
    vrq_pkg::result_t res_reg, res_next, res;
    logic          valid_reg, valid_next;
    logic          emit;

    logic          take;
    logic [FW-1:0] free_bytes;
    logic [vrq_pkg::TOTAL_W-1:0] total_w;
    logic          no_space;
    logic [63:0]   hdr_full;
    logic [31:0]   payload;

    assign take      = (state_reg == vrq_pkg::BK_IDLE) && in_valid
                       && (!valid_reg || out_ready);
    assign in_pop    = take;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    assign free_bytes = (head_reg > tail_reg) ? (FW'(head_reg) - FW'(tail_reg))
                        : (FW'(head_reg) + FW'(RING_BYTES) - FW'(tail_reg));
    assign total_w  = vrq_pkg::TOTAL_W'(in_item.write_length)
                      + vrq_pkg::TOTAL_W'(vrq_pkg::HEADER_BYTES);
    assign no_space = CW'(free_bytes) <= CW'(total_w);
    // header bytes arrive lowest first; last one is still on the read port
    assign hdr_full = {ring_rdata_reg, hdr_reg[63:8]};
    assign payload  = hdr_full[31:0] - 32'(vrq_pkg::HEADER_BYTES);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vrq_pkg::BK_IDLE: begin
                if (take) begin
                    case (in_item.action)
                        vrq_pkg::ACT_START_WRITE: begin
                            if (wleft_reg == '0 && !no_space) state_next = vrq_pkg::BK_WR_HDR;
                        end
                        vrq_pkg::ACT_START_READ: begin
                            if (rleft_reg == '0 && head_reg != tail_reg)
                                state_next = vrq_pkg::BK_RD_HDR;
                        end
                        vrq_pkg::ACT_READ_BYTE: begin
                            if (rleft_reg != '0) state_next = vrq_pkg::BK_RD_BYTE;
                        end
                        default: state_next = vrq_pkg::BK_IDLE;
                    endcase
                end
            end
            vrq_pkg::BK_WR_HDR: begin
                if (cnt_reg == 4'd7) state_next = vrq_pkg::BK_IDLE;
            end
            vrq_pkg::BK_RD_HDR: begin
                if (cnt_reg == 4'd8) state_next = vrq_pkg::BK_IDLE;
            end
            vrq_pkg::BK_RD_BYTE: state_next = vrq_pkg::BK_IDLE;
            default: state_next = vrq_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        wcur_next  = wcur_reg;
        rcur_next  = rcur_reg;
        addr_next  = addr_reg;
        wleft_next = wleft_reg;
        rleft_next = rleft_reg;
        enq_next   = enq_reg;
        deq_next   = deq_reg;
        cnt_next   = cnt_reg;
        hdr_next   = hdr_reg;
        item_next  = item_reg;
        mem_we     = 1'b0;
        store_addr = addr_reg;
        mem_wdata  = hdr_reg[7:0];
        emit       = 1'b0;
        res        = '0;
        res.status = vrq_pkg::ST_OK;

        case (state_reg)
            vrq_pkg::BK_IDLE: begin
                if (take) begin
                    item_next = in_item;
                    cnt_next  = '0;
                    case (in_item.action)
                        vrq_pkg::ACT_START_WRITE: begin
                            emit = 1'b1;
                            if (wleft_reg != '0) begin
                                res.status = vrq_pkg::ST_OUT_OF_SEQ;
                            end else if (no_space) begin
                                res.status = vrq_pkg::ST_NO_SPACE;
                            end else begin
                                hdr_next   = {in_item.flow_tag, 32'(total_w)};
                                addr_next  = tail_reg;
                                wleft_next = in_item.write_length;
                                enq_next   = enq_reg + 32'd1;
                                res.status = (free_bytes == FW'(RING_BYTES))
                                             ? vrq_pkg::ST_OK_EMPTY : vrq_pkg::ST_OK;
                            end
                        end
                        vrq_pkg::ACT_WRITE_BYTE: begin
                            emit = 1'b1;
                            if (wleft_reg == '0) begin
                                res.status = vrq_pkg::ST_OUT_OF_SEQ;
                            end else begin
                                mem_we     = 1'b1;
                                store_addr = wcur_reg;
                                mem_wdata  = in_item.data_in;
                                wcur_next  = ring_inc(wcur_reg);
                                wleft_next = wleft_reg - LW'(1);
                                if (wleft_reg == LW'(1)) tail_next = ring_inc(wcur_reg);
                            end
                        end
                        vrq_pkg::ACT_START_READ: begin
                            if (rleft_reg != '0) begin
                                emit       = 1'b1;
                                res.status = vrq_pkg::ST_OUT_OF_SEQ;
                            end else if (head_reg == tail_reg) begin
                                emit       = 1'b1;
                                res.status = vrq_pkg::ST_EMPTY;
                            end else begin
                                addr_next = head_reg;
                            end
                        end
                        vrq_pkg::ACT_READ_BYTE: begin
                            if (rleft_reg == '0) begin
                                emit       = 1'b1;
                                res.status = vrq_pkg::ST_OUT_OF_SEQ;
                            end else begin
                                store_addr = rcur_reg;
                            end
                        end
                        default: emit = 1'b0;
                    endcase
                end
            end
            vrq_pkg::BK_WR_HDR: begin
                mem_we    = 1'b1;
                hdr_next  = {8'd0, hdr_reg[63:8]};
                addr_next = ring_inc(addr_reg);
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd7) begin
                    wcur_next = ring_inc(addr_reg);
                    if (wleft_reg == '0) tail_next = ring_inc(addr_reg);
                end
            end
            vrq_pkg::BK_RD_HDR: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg != 4'd8) addr_next = ring_inc(addr_reg);
                if (cnt_reg != 4'd0) hdr_next = hdr_full;
                if (cnt_reg == 4'd8) begin
                    emit            = 1'b1;
                    deq_next        = deq_reg + 32'd1;
                    res.read_length = payload[LW-1:0];
                    res.read_flow   = hdr_full[63:32];
                    if (payload > 32'(item_reg.read_limit)) begin
                        res.status = vrq_pkg::ST_OVER_LIM;
                    end else begin
                        rcur_next  = addr_reg;
                        rleft_next = payload[LW-1:0];
                        if (payload == 32'd0) head_next = addr_reg;
                    end
                end
            end
            vrq_pkg::BK_RD_BYTE: begin
                emit         = 1'b1;
                res.data_out = ring_rdata_reg;
                rcur_next    = ring_inc(rcur_reg);
                rleft_next   = rleft_reg - LW'(1);
                if (rleft_reg == LW'(1)) begin
                    res.last_byte = 1'b1;
                    head_next     = ring_inc(rcur_reg);
                end
            end
            default: emit = 1'b0;
        endcase

        res.enqueued_total = enq_next;
        res.dequeued_total = deq_next;
        valid_next = (valid_reg && !out_ready) || emit;
        res_next   = emit ? res : res_reg;
    end

    // single-port store, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[store_addr] <= mem_wdata;
        end
        ring_rdata_reg <= ring_mem[store_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vrq_pkg::BK_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            wcur_reg  <= '0;
            rcur_reg  <= '0;
            wleft_reg <= '0;
            rleft_reg <= '0;
            enq_reg   <= '0;
            deq_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            wcur_reg  <= wcur_next;
            rcur_reg  <= rcur_next;
            wleft_reg <= wleft_next;
            rleft_reg <= rleft_next;
            enq_reg   <= enq_next;
            deq_reg   <= deq_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        hdr_reg  <= hdr_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

endmodule

### src/variable_record_ring_queue.sv
// Variable-length record ring queue: input stream of actions, one result beat
// per input beat. Depends on vrq_pkg, vrq_front and vrq_back.
//
// Usage: each s_ beat carries one action (s_tuser): start_write with length
// and flow tag, write_byte with one payload byte, start_read with a read
// limit, or read_byte. Each input beat produces exactly one m_ beat with a
// status (m_tuser), read length/flow, data byte, the message-end flag on
// m_tlast, and both message counters.
// Timing: write_byte, start_write and out-of-sequence/rejected beats give
// their result from the back end's idle state into the result register;
// read_byte first reads the store (BK_RD_BYTE); start_read first reads the
// eight header bytes (BK_RD_HDR). An accepted start_write then keeps the back
// end busy in BK_WR_HDR while the header goes through the single store port.
// Each beat is registered in the front queue before it reaches the back end.
// A two-beat front queue keeps s_tready high while the back end is busy or
// a result waits, until the queue fills. If m_tready stays low, the result
// register holds and the front queue fills, then s_tready drops.
// Reset clears pointers, counters and queues; the store contents are
// undefined until written and need no clearing.
module variable_record_ring_queue #(
    parameter int RING_BYTES = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [12:0] write_length, [44:13] flow_tag, [52:45] data_in,
    // [65:53] read_limit, [71:66] zero
    input  logic [71:0]  s_tdata,
    // [1:0] action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [12:0] read_length, [44:13] read_flow, [52:45] data_out,
    // [84:53] enqueued_total, [116:85] dequeued_total, [119:117] zero
    output logic [119:0] m_tdata,
    // [2:0] status
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    vrq_pkg::item_t   s_item, q_item;
    vrq_pkg::result_t m_res;
    logic             q_valid, q_pop;

    always_comb begin
        s_item.action       = vrq_pkg::action_t'(s_tuser);
        s_item.write_length = s_tdata[12:0];
        s_item.flow_tag     = s_tdata[44:13];
        s_item.data_in      = s_tdata[52:45];
        s_item.read_limit   = s_tdata[65:53];
    end

    vrq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    vrq_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_item   (q_item),
        .in_pop    (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res)
    );

    assign m_tdata = {3'd0, m_res.dequeued_total, m_res.enqueued_total,
                      m_res.data_out, m_res.read_flow, m_res.read_length};
    assign m_tuser = m_res.status;
    assign m_tlast = m_res.last_byte;

endmodule
